[hdl/c2dmac_pkg.sv]
// Shared types, sizes and address functions for the conv2d_layer_mac block.
// Depends on nothing; imported by hdl/conv2d_layer_mac.sv.
package c2dmac_pkg;

  // Store dimensions
  localparam int MAX_CHANNELS = 32;
  localparam int MAX_KERNELS  = 32;
  localparam int MAX_DIM      = 32;
  localparam int MAX_TAP      = 9;

  localparam int TAPS       = MAX_TAP * MAX_TAP;
  localparam int FEAT_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
  localparam int WGT_DEPTH  = MAX_KERNELS * MAX_CHANNELS * TAPS;
  localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
  localparam int WGT_AW     = $clog2(WGT_DEPTH);
  localparam int DIM_W      = $clog2(MAX_DIM);

  // Accumulator: up to 2592 products of 2^30 plus a shifted bias
  localparam int ACC_W = 48;
  localparam int CFG_W = 6;

  typedef enum logic [1:0] {
    KIND_WEIGHT  = 2'd0,
    KIND_BIAS    = 2'd1,
    KIND_FEATURE = 2'd2,
    KIND_REQUEST = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_IN_CHANNELS   = 3'd0,
    CFG_IN_HEIGHT     = 3'd1,
    CFG_IN_WIDTH      = 3'd2,
    CFG_KERNEL_HEIGHT = 3'd3,
    CFG_KERNEL_WIDTH  = 3'd4,
    CFG_STRIDE_STEP   = 3'd5,
    CFG_PAD_WIDTH     = 3'd6,
    CFG_RELU_ENABLE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CALC,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [4:0]         kernel_index;
    logic [4:0]         channel_index;
    logic [3:0]         tap_row;
    logic [3:0]         tap_col;
    logic [4:0]         pixel_row;
    logic [4:0]         pixel_col;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic signed [15:0] value;
  } item_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               out_of_range;
  } result_t;

  function automatic logic [FEAT_AW-1:0] feat_addr(logic [4:0] ch, logic [DIM_W-1:0] row,
                                                   logic [DIM_W-1:0] col);
    return FEAT_AW'(ch) * FEAT_AW'(MAX_DIM * MAX_DIM) + FEAT_AW'(row) * FEAT_AW'(MAX_DIM)
           + FEAT_AW'(col);
  endfunction

  function automatic logic [WGT_AW-1:0] wgt_addr(logic [4:0] kn, logic [4:0] ch,
                                                 logic [3:0] tr, logic [3:0] tc);
    return WGT_AW'(kn) * WGT_AW'(MAX_CHANNELS * TAPS) + WGT_AW'(ch) * WGT_AW'(TAPS)
           + WGT_AW'(tr) * WGT_AW'(MAX_TAP) + WGT_AW'(tc);
  endfunction

endpackage

[hdl/conv2d_layer_mac.sv]
// Convolution layer engine: feature, weight and bias stores and one shared MAC.
// Depends on hdl/c2dmac_pkg.sv.
//
// Usage: an item is taken on a rising edge with start_i high and busy_o low.
// Weight, bias and feature writes give no result and leave busy_o low.
// A request raises busy_o through a setup state, then a calculation state that visits
// every kernel tap of every channel (in_channels * kernel_height * kernel_width, at
// most 2592 taps), a drain state, shorter when the last taps fall in the zero border,
// that waits for the last product, and a rounding state. Each tap read passes through
// the single multiply-accumulate path (feature/weight read, multiply, add).
// A request outside the output size returns from the setup state with out_of_range
// set and result zero.
// The result is on result_o for one cycle, flagged by result_valid_o, in the first
// cycle with busy_o low; the receiver cannot stall it. A new item may be taken in
// that same cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write one register per edge; the user
// must write only while the block is idle, which the block itself does not enforce.
// Reset restores the register defaults and returns to idle; store contents stay
// undefined until written.
module conv2d_layer_mac
  import c2dmac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  item_t            item_i,
  output logic             result_valid_o,
  output result_t          result_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [5:0] cfg_ch_q, cfg_h_q, cfg_w_q;
  logic [3:0] cfg_kh_q, cfg_kw_q, cfg_s_q;
  logic [2:0] cfg_pad_q;
  logic       cfg_relu_q;

  // Effective (clamped) configuration
  logic [5:0] nch, dim_h, dim_w;
  logic [3:0] kh, kw, stride;

  state_e state_q, state_d;

  logic [4:0]  kn_q, kn_d;
  logic [5:0]  orow_q, orow_d, ocol_q, ocol_d;
  logic [9:0]  rbase_q, rbase_d, cbase_q, cbase_d;
  logic [4:0]  c_q, c_d;
  logic [3:0]  i_q, i_d, j_q, j_d;
  logic        p1_q, p1_d, p2_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic        res_vld_q, res_vld_d;
  result_t     res_q, res_d;

  // Store data path
  logic signed [15:0] fmem [FEAT_DEPTH];
  logic signed [15:0] wmem [WGT_DEPTH];
  logic signed [15:0] bmem [MAX_KERNELS];
  logic signed [15:0] fdata_q, wdata_q, bias_q;
  logic signed [31:0] prod_q;

  logic accept, wr_wgt, wr_bias, wr_feat, rd_en, ld_bias;
  logic [9:0]  rmul, cmul;
  logic        in_range;
  logic [10:0] py, px, py_off, px_off;
  logic        tap_ok, last_tap;
  logic [FEAT_AW-1:0] rd_faddr;
  logic [WGT_AW-1:0]  rd_waddr;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-9:0] quo;

  assign busy_o         = (state_q != ST_IDLE);
  assign accept         = start_i && !busy_o;
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  always_comb begin
    nch    = (cfg_ch_q == 6'd0) ? 6'd1 :
             (cfg_ch_q > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS) : cfg_ch_q;
    dim_h  = (cfg_h_q == 6'd0) ? 6'd1 : (cfg_h_q > 6'(MAX_DIM)) ? 6'(MAX_DIM) : cfg_h_q;
    dim_w  = (cfg_w_q == 6'd0) ? 6'd1 : (cfg_w_q > 6'(MAX_DIM)) ? 6'(MAX_DIM) : cfg_w_q;
    kh     = (cfg_kh_q == 4'd0) ? 4'd1 : (cfg_kh_q > 4'(MAX_TAP)) ? 4'(MAX_TAP) : cfg_kh_q;
    kw     = (cfg_kw_q == 4'd0) ? 4'd1 : (cfg_kw_q > 4'(MAX_TAP)) ? 4'(MAX_TAP) : cfg_kw_q;
    stride = (cfg_s_q == 4'd0) ? 4'd1 : cfg_s_q;
  end

  assign wr_wgt  = accept && item_i.kind == KIND_WEIGHT
                   && int'(item_i.kernel_index) < MAX_KERNELS
                   && int'(item_i.channel_index) < MAX_CHANNELS
                   && int'(item_i.tap_row) < MAX_TAP && int'(item_i.tap_col) < MAX_TAP;
  assign wr_bias = accept && item_i.kind == KIND_BIAS
                   && int'(item_i.kernel_index) < MAX_KERNELS;
  assign wr_feat = accept && item_i.kind == KIND_FEATURE
                   && int'(item_i.channel_index) < MAX_CHANNELS
                   && int'(item_i.pixel_row) < MAX_DIM && int'(item_i.pixel_col) < MAX_DIM;

  // Window origin in padded coordinates; a position is valid when o*s + k <= dim + 2*pad
  assign rmul     = 10'(orow_q) * 10'(stride);
  assign cmul     = 10'(ocol_q) * 10'(stride);
  assign in_range = int'(kn_q) < MAX_KERNELS
                    && (11'(rmul) + 11'(kh)) <= (11'(dim_h) + 11'({cfg_pad_q, 1'b0}))
                    && (11'(cmul) + 11'(kw)) <= (11'(dim_w) + 11'({cfg_pad_q, 1'b0}));

  // Current tap; taps in the zero border are skipped, not read
  assign py       = 11'(rbase_q) + 11'(i_q);
  assign px       = 11'(cbase_q) + 11'(j_q);
  assign py_off   = py - 11'(cfg_pad_q);
  assign px_off   = px - 11'(cfg_pad_q);
  assign tap_ok   = py >= 11'(cfg_pad_q) && py_off < 11'(dim_h)
                    && px >= 11'(cfg_pad_q) && px_off < 11'(dim_w);
  assign rd_faddr = feat_addr(c_q, py_off[DIM_W-1:0], px_off[DIM_W-1:0]);
  assign rd_waddr = wgt_addr(kn_q, c_q, i_q, j_q);
  assign last_tap = (c_q == 5'(nch - 6'd1)) && (i_q == kh - 4'd1) && (j_q == kw - 4'd1);

  // Round half up to Q8.8: floor((acc + bias*256 + 128) / 256)
  assign sum = acc_q + (ACC_W'(bias_q) <<< 8) + ACC_W'(128);
  assign quo = sum[ACC_W-1:8];

  always_comb begin
    state_d   = state_q;
    kn_d      = kn_q;
    orow_d    = orow_q;
    ocol_d    = ocol_q;
    rbase_d   = rbase_q;
    cbase_d   = cbase_q;
    c_d       = c_q;
    i_d       = i_q;
    j_d       = j_q;
    p1_d      = 1'b0;
    acc_d     = p2_q ? acc_q + ACC_W'(prod_q) : acc_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    rd_en     = 1'b0;
    ld_bias   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_i.kind == KIND_REQUEST) begin
          kn_d    = item_i.kernel_index;
          orow_d  = item_i.out_row;
          ocol_d  = item_i.out_col;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (!in_range) begin
          res_vld_d          = 1'b1;
          res_d.result       = '0;
          res_d.out_of_range = 1'b1;
          state_d            = ST_IDLE;
        end else begin
          rbase_d = rmul;
          cbase_d = cmul;
          c_d     = '0;
          i_d     = '0;
          j_d     = '0;
          acc_d   = '0;
          ld_bias = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        rd_en = tap_ok;
        p1_d  = tap_ok;
        if (j_q == kw - 4'd1) begin
          j_d = '0;
          if (i_q == kh - 4'd1) begin
            i_d = '0;
            c_d = c_q + 5'd1;
          end else begin
            i_d = i_q + 4'd1;
          end
        end else begin
          j_d = j_q + 4'd1;
        end
        if (last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last product has reached the accumulator
        if (!p1_q && !p2_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        res_vld_d          = 1'b1;
        res_d.out_of_range = 1'b0;
        if (cfg_relu_q && quo < 0) begin
          res_d.result = '0;
        end else if (quo > ACC_W'(32767)) begin
          res_d.result = 16'sh7fff;
        end else if (quo < -(ACC_W'(32768))) begin
          res_d.result = 16'sh8000;
        end else begin
          res_d.result = quo[15:0];
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kn_q      <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      rbase_q   <= '0;
      cbase_q   <= '0;
      c_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      acc_q     <= '0;
      res_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      kn_q      <= kn_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      rbase_q   <= rbase_d;
      cbase_q   <= cbase_d;
      c_q       <= c_d;
      i_q       <= i_d;
      j_q       <= j_d;
      p1_q      <= p1_d;
      p2_q      <= p1_q;
      acc_q     <= acc_d;
      res_vld_q <= res_vld_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ch_q   <= 6'd1;
      cfg_h_q    <= 6'd32;
      cfg_w_q    <= 6'd32;
      cfg_kh_q   <= 4'd3;
      cfg_kw_q   <= 4'd3;
      cfg_s_q    <= 4'd1;
      cfg_pad_q  <= 3'd0;
      cfg_relu_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IN_CHANNELS:   cfg_ch_q   <= cfg_data_i[5:0];
        CFG_IN_HEIGHT:     cfg_h_q    <= cfg_data_i[5:0];
        CFG_IN_WIDTH:      cfg_w_q    <= cfg_data_i[5:0];
        CFG_KERNEL_HEIGHT: cfg_kh_q   <= cfg_data_i[3:0];
        CFG_KERNEL_WIDTH:  cfg_kw_q   <= cfg_data_i[3:0];
        CFG_STRIDE_STEP:   cfg_s_q    <= cfg_data_i[3:0];
        CFG_PAD_WIDTH:     cfg_pad_q  <= cfg_data_i[2:0];
        CFG_RELU_ENABLE:   cfg_relu_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stores, registered reads and the multiplier stage
  always_ff @(posedge clk_i) begin
    if (wr_feat) begin
      fmem[feat_addr(item_i.channel_index, item_i.pixel_row[DIM_W-1:0],
                     item_i.pixel_col[DIM_W-1:0])] <= item_i.value;
    end
    if (wr_wgt) begin
      wmem[wgt_addr(item_i.kernel_index, item_i.channel_index, item_i.tap_row,
                    item_i.tap_col)] <= item_i.value;
    end
    if (wr_bias) begin
      bmem[item_i.kernel_index] <= item_i.value;
    end
    if (rd_en) begin
      fdata_q <= fmem[rd_faddr];
      wdata_q <= wmem[rd_waddr];
    end
    if (ld_bias) begin
      bias_q <= bmem[kn_q];
    end
    if (p1_q) begin
      prod_q <= fdata_q * wdata_q;
    end
  end

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (!p1_q && !p2_q))
    else $error("MAC pipeline busy while idle");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.out_of_range) |-> (result_o.result == 16'sd0))
    else $error("out-of-range result not zero");

  a_relu_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && cfg_relu_q) |-> !result_o.result[15])
    else $error("negative result with ReLU enabled");

  a_request_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind == KIND_REQUEST) |=> (busy_o && !result_valid_o))
    else $error("request not taken into the sequencer");

endmodule
